### design/bxds_pkg.sv
`default_nettype none

package bxds_pkg;

  // Fixed field widths of the pixel and result beats.
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 12;
  localparam int NUM_CH     = 3;

  // Configuration register widths and frame limits.
  localparam int KERN_REG_W = 5;
  localparam int DIM_REG_W  = 13;
  localparam int MAX_HEIGHT = 4096;

  // APB port geometry: three registers on a 32-bit data bus at 0x0, 0x4, 0x8.
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [KERN_REG_W-1:0] KERN_RESET   = 5'd1;
  localparam logic [DIM_REG_W-1:0]  WIDTH_RESET  = 13'd640;
  localparam logic [DIM_REG_W-1:0]  HEIGHT_RESET = 13'd480;

  typedef enum logic [1:0] {
    IDX_KERNEL = 2'd0,
    IDX_WIDTH  = 2'd1,
    IDX_HEIGHT = 2'd2,
    IDX_NONE   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WB,
    ST_DIV
  } bxds_state_e;

  // Divider handshake from the control FSM.
  typedef struct packed {
    logic start;
    logic ack;
  } div_ctl_t;

endpackage

`default_nettype wire

### design/bxds_if.sv
`default_nettype none

interface bxds_pix_if import bxds_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_red;
  logic [PIX_W-1:0] pixel_green;
  logic [PIX_W-1:0] pixel_blue;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface bxds_mean_if import bxds_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   mean_red;
  logic [PIX_W-1:0]   mean_green;
  logic [PIX_W-1:0]   mean_blue;
  logic [COORD_W-1:0] out_column;
  logic [COORD_W-1:0] out_line;

  modport source (output valid, mean_red, mean_green, mean_blue, out_column, out_line,
                  input ready);
  modport sink   (input valid, mean_red, mean_green, mean_blue, out_column, out_line,
                  output ready);
endinterface

`default_nettype wire

### design/bxds_colmem.sv
`default_nettype none

module bxds_colmem #(
  parameter int DEPTH = 4096,
  parameter int DW    = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### design/bxds_div.sv
`default_nettype none

module bxds_div import bxds_pkg::*; #(
  parameter int SW = 16,
  parameter int AW = 9
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire div_ctl_t                  ctl_i,
  input  wire logic [NUM_CH-1:0][SW-1:0] dividend_i,
  input  wire logic [AW-1:0]             divisor_i,
  output logic                           done_o,
  output logic      [NUM_CH-1:0][SW-1:0] quotient_o
);

  localparam int CNT_W = $clog2(SW + 1);

  logic                      busy_q, busy_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [AW-1:0]             dvs_q, dvs_d;
  logic [NUM_CH-1:0][AW-1:0] rem_q, rem_d;
  logic [NUM_CH-1:0][SW-1:0] quo_q, quo_d;
  logic [AW:0]               shifted;

  // One restoring step per cycle, all three channels side by side.
  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    shifted = '0;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SW);
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q && (cnt_q != '0)) begin
      cnt_d = cnt_q - 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        shifted = {rem_q[c], quo_q[c][SW-1]};
        if (shifted >= {1'b0, dvs_q}) begin
          rem_d[c] = AW'(shifted - {1'b0, dvs_q});
          quo_d[c] = {quo_q[c][SW-2:0], 1'b1};
        end else begin
          rem_d[c] = shifted[AW-1:0];
          quo_d[c] = {quo_q[c][SW-2:0], 1'b0};
        end
      end
    end else if (ctl_i.ack) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### design/rgb_box_average_downsampler_unit.sv
`default_nettype none

// K-by-K box-average downsampler for an RGB888 raster. Pixels enter one beat
// at a time in raster order on pix_i; every complete K-by-K block yields one
// beat on mean_o carrying floor(channel sum / K*K) for red, green and blue
// plus the block's column and line in the downsampled image. Pixels in the
// trailing columns and lines that do not fill a whole block are dropped.
// Registers over APB: 0x0 kernel_size (1..MAX_KERNEL, 0 acts as 1), 0x4
// image_width (1..MAX_WIDTH), 0x8 image_height (1..4096); any write, even to
// an unused address, restarts the frame. Write registers only while idle.
// Flow: a pixel that is not the last of its block row, or that is dropped,
// is taken without a stall. After the last pixel of a block row the input is
// held for the write-back state, because the per-block-column sum lives in a
// RAM with a registered read port and is read, added and written back. After
// the pixel that completes a block the input is also held for the SW restoring
// steps in the shared divider and for the load of the output register.
// If the previous result has not been taken yet, the load waits until it is,
// so a result waiting in the output register stalls the input only once the
// next block completes. The column-sum RAM needs no clearing after reset: on
// the first line of a block band each entry is written without its old value.
module rgb_box_average_downsampler_unit import bxds_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_KERNEL = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  bxds_pix_if.sink               pix_i,
  bxds_mean_if.source            mean_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  // Column counters and RAM index.
  localparam int CIW  = $clog2(MAX_WIDTH);
  localparam int CW   = CIW + 1;
  // In-block counters and kernel size.
  localparam int KIW  = $clog2(MAX_KERNEL);
  localparam int KW   = KIW + 1;
  // Line counters, height holds MAX_HEIGHT itself.
  localparam int LW   = COORD_W;
  localparam int HW   = LW + 1;
  // Row sum, column sum and block area widths.
  localparam int RSW  = $clog2(MAX_KERNEL * 255 + 1);
  localparam int SW   = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
  localparam int AW   = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  // Compare widths wide enough for base + K.
  localparam int CCW  = CW + KW;
  localparam int LCW  = HW + KW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [KERN_REG_W-1:0] kernel_q, kernel_d;
  logic [DIM_REG_W-1:0]  width_q, width_d;
  logic [DIM_REG_W-1:0]  height_q, height_d;
  logic                  cfg_wr;
  reg_idx_e              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    kernel_d = kernel_q;
    width_d  = width_q;
    height_d = height_q;
    prdata   = '0;
    unique case (cfg_idx)
      IDX_KERNEL: begin
        prdata = APB_DW'(kernel_q);
        if (cfg_wr) kernel_d = pwdata[KERN_REG_W-1:0];
      end
      IDX_WIDTH: begin
        prdata = APB_DW'(width_q);
        if (cfg_wr) width_d = pwdata[DIM_REG_W-1:0];
      end
      IDX_HEIGHT: begin
        prdata = APB_DW'(height_q);
        if (cfg_wr) height_d = pwdata[DIM_REG_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q <= KERN_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else begin
      kernel_q <= kernel_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Clamp registers to the supported range; zero acts as one.
  logic [31:0]   k_full, w_full, h_full;
  logic [KW-1:0] k_eff;
  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (kernel_q == '0) k_full = 32'd1;
    else if (32'(kernel_q) > 32'(MAX_KERNEL)) k_full = 32'(MAX_KERNEL);
    else k_full = 32'(kernel_q);

    if (width_q == '0) w_full = 32'd1;
    else if (32'(width_q) > 32'(MAX_WIDTH)) w_full = 32'(MAX_WIDTH);
    else w_full = 32'(width_q);

    if (height_q == '0) h_full = 32'd1;
    else if (32'(height_q) > 32'(MAX_HEIGHT)) h_full = 32'(MAX_HEIGHT);
    else h_full = 32'(height_q);
  end

  assign k_eff = k_full[KW-1:0];
  assign w_eff = w_full[CW-1:0];
  assign h_eff = h_full[HW-1:0];

  // ---------------------------------------------------------------------------
  // Raster position
  // ---------------------------------------------------------------------------
  logic [CIW-1:0] icol_q, icol_d;       // input column
  logic [LW-1:0]  iline_q, iline_d;     // input line
  logic [KIW-1:0] cib_q, cib_d;         // column inside block
  logic [KIW-1:0] lib_q, lib_d;         // line inside block
  logic [CIW-1:0] bcol_q, bcol_d;       // block column
  logic [LW-1:0]  bline_q, bline_d;     // block line
  logic [CIW-1:0] col_base_q, col_base_d;   // first input column of the block
  logic [LW-1:0]  line_base_q, line_base_d; // first input line of the band

  logic [NUM_CH-1:0][RSW-1:0] row_sum_q, row_sum_d;
  logic [NUM_CH-1:0][RSW-1:0] pix_sum;
  logic [NUM_CH-1:0][PIX_W-1:0] pix_in;

  logic col_last, line_last, line_end, frame_end, blk_ok;

  assign pix_in[0] = pix_i.pixel_red;
  assign pix_in[1] = pix_i.pixel_green;
  assign pix_in[2] = pix_i.pixel_blue;

  assign col_last  = (KW'(cib_q) + KW'(1)) == k_eff;
  assign line_last = (KW'(lib_q) + KW'(1)) == k_eff;
  assign line_end  = (CW'(icol_q) + CW'(1)) >= w_eff;
  assign frame_end = (HW'(iline_q) + HW'(1)) >= h_eff;
  // The block holding this pixel lies wholly inside the frame.
  assign blk_ok    = ((CCW'(col_base_q) + CCW'(k_eff)) <= CCW'(w_eff)) &&
                     ((LCW'(line_base_q) + LCW'(k_eff)) <= LCW'(h_eff));

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      pix_sum[c] = row_sum_q[c] + RSW'(pix_in[c]);
    end
  end

  // ---------------------------------------------------------------------------
  // Control FSM
  // ---------------------------------------------------------------------------
  bxds_state_e state_q, state_d;
  logic        pix_acc;
  logic        col_flush;   // accepted pixel closes a block row
  logic        pix_rdy;
  logic        mem_re, mem_we;
  logic        out_load;
  logic        div_done;
  div_ctl_t    div_ctl;

  logic pend_first_q, pend_emit_q;

  assign pix_acc   = pix_i.valid && pix_rdy;
  assign col_flush = pix_acc && blk_ok && col_last;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (col_flush) state_d = ST_WB;
      end
      ST_WB: begin
        state_d = pend_emit_q ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (div_done && (!mean_o.valid || mean_o.ready)) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pix_rdy       = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    out_load      = 1'b0;
    div_ctl.start = 1'b0;
    div_ctl.ack   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        pix_rdy = 1'b1;
        mem_re  = pix_i.valid && blk_ok && col_last;
      end
      ST_WB: begin
        mem_we        = 1'b1;
        div_ctl.start = pend_emit_q;
      end
      ST_DIV: begin
        out_load    = div_done && (!mean_o.valid || mean_o.ready);
        div_ctl.ack = out_load;
      end
      default: begin
        pix_rdy = 1'b0;
      end
    endcase
  end

  assign pix_i.ready = pix_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Position and row-sum update
  // ---------------------------------------------------------------------------
  always_comb begin
    icol_d      = icol_q;
    iline_d     = iline_q;
    cib_d       = cib_q;
    lib_d       = lib_q;
    bcol_d      = bcol_q;
    bline_d     = bline_q;
    col_base_d  = col_base_q;
    line_base_d = line_base_q;
    row_sum_d   = row_sum_q;

    if (pix_acc) begin
      // Accumulate, or hand the finished block row to write-back.
      if (blk_ok) begin
        row_sum_d = col_last ? '0 : pix_sum;
      end

      icol_d = icol_q + 1'b1;
      cib_d  = cib_q + 1'b1;
      if (col_last) begin
        cib_d      = '0;
        bcol_d     = bcol_q + 1'b1;
        col_base_d = CIW'(CCW'(col_base_q) + CCW'(k_eff));
      end

      if (line_end) begin
        icol_d     = '0;
        cib_d      = '0;
        bcol_d     = '0;
        col_base_d = '0;
        row_sum_d  = '0;
        iline_d    = iline_q + 1'b1;
        lib_d      = lib_q + 1'b1;
        if (line_last) begin
          lib_d       = '0;
          bline_d     = bline_q + 1'b1;
          line_base_d = LW'(LCW'(line_base_q) + LCW'(k_eff));
        end
        if (frame_end) begin
          iline_d     = '0;
          lib_d       = '0;
          bline_d     = '0;
          line_base_d = '0;
        end
      end
    end

    // Any register write restarts the frame.
    if (cfg_wr) begin
      icol_d      = '0;
      iline_d     = '0;
      cib_d       = '0;
      lib_d       = '0;
      bcol_d      = '0;
      bline_d     = '0;
      col_base_d  = '0;
      line_base_d = '0;
      row_sum_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icol_q      <= '0;
      iline_q     <= '0;
      cib_q       <= '0;
      lib_q       <= '0;
      bcol_q      <= '0;
      bline_q     <= '0;
      col_base_q  <= '0;
      line_base_q <= '0;
      row_sum_q   <= '0;
    end else begin
      icol_q      <= icol_d;
      iline_q     <= iline_d;
      cib_q       <= cib_d;
      lib_q       <= lib_d;
      bcol_q      <= bcol_d;
      bline_q     <= bline_d;
      col_base_q  <= col_base_d;
      line_base_q <= line_base_d;
      row_sum_q   <= row_sum_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pending block-row write-back
  // ---------------------------------------------------------------------------
  logic [NUM_CH-1:0][RSW-1:0] pend_sum_q;
  logic [CIW-1:0]             pend_addr_q;
  logic [COORD_W-1:0]         pend_col_q, pend_line_q;
  logic [COORD_W-1:0]         res_col_q, res_line_q;

  // Capture on the pixel that closes a block row; only one is in flight.
  always_ff @(posedge clk_i) begin
    if (col_flush) begin
      pend_sum_q   <= pix_sum;
      pend_addr_q  <= bcol_q;
      pend_first_q <= (lib_q == '0);
      pend_emit_q  <= line_last;
      pend_col_q   <= COORD_W'(bcol_q);
      pend_line_q  <= bline_q;
    end
  end

  logic [NUM_CH-1:0][SW-1:0] mem_rdata, new_sum;
  logic [NUM_CH*SW-1:0]      mem_rdata_flat;

  assign mem_rdata = mem_rdata_flat;

  // First line of a band overwrites; later lines accumulate.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      new_sum[c] = (pend_first_q ? SW'(0) : mem_rdata[c]) + SW'(pend_sum_q[c]);
    end
  end

  bxds_colmem #(
    .DEPTH (MAX_WIDTH),
    .DW    (NUM_CH * SW)
  ) u_colmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pend_addr_q),
    .wdata_i (new_sum),
    .re_i    (mem_re),
    .raddr_i (bcol_q),
    .rdata_o (mem_rdata_flat)
  );

  // ---------------------------------------------------------------------------
  // Block mean: divide the column sums by K*K
  // ---------------------------------------------------------------------------
  logic [2*KW-1:0]           area_full;
  logic [NUM_CH-1:0][SW-1:0] quotient;

  assign area_full = (2*KW)'(k_eff) * (2*KW)'(k_eff);

  bxds_div #(
    .SW (SW),
    .AW (AW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (new_sum),
    .divisor_i  (AW'(area_full)),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Hold the block position alongside the divider.
  always_ff @(posedge clk_i) begin
    if (div_ctl.start) begin
      res_col_q  <= pend_col_q;
      res_line_q <= pend_line_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                           out_valid_q, out_valid_d;
  logic [NUM_CH-1:0][PIX_W-1:0]   out_mean_q;
  logic [COORD_W-1:0]             out_col_q, out_line_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (mean_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_mean_q[c] <= quotient[c][PIX_W-1:0];
      end
      out_col_q  <= res_col_q;
      out_line_q <= res_line_q;
    end
  end

  assign mean_o.valid      = out_valid_q;
  assign mean_o.mean_red   = out_mean_q[0];
  assign mean_o.mean_green = out_mean_q[1];
  assign mean_o.mean_blue  = out_mean_q[2];
  assign mean_o.out_column = out_col_q;
  assign mean_o.out_line   = out_line_q;

endmodule

`default_nettype wire

### design/bxds_checker.sv
`default_nettype none

module bxds_checker import bxds_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               pix_valid_i,
  input wire logic               pix_ready_i,
  input wire logic               mean_valid_i,
  input wire logic               mean_ready_i,
  input wire logic [PIX_W-1:0]   mean_red_i,
  input wire logic [PIX_W-1:0]   mean_green_i,
  input wire logic [PIX_W-1:0]   mean_blue_i,
  input wire logic [COORD_W-1:0] out_column_i,
  input wire logic [COORD_W-1:0] out_line_i,
  input wire logic               pready_i
);

  // Hold a stalled result beat.
  a_mean_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_valid_i && !mean_ready_i |=> mean_valid_i && $stable(mean_red_i) &&
      $stable(mean_green_i) && $stable(mean_blue_i) && $stable(out_column_i) &&
      $stable(out_line_i))
    else $error("result beat changed while stalled");

  // Drop any pending result while in reset.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !mean_valid_i)
    else $error("result valid during reset");

  // The APB port never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("pready low");

  // A result appears only out of the divider, never right after a pixel beat.
  a_rise_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mean_valid_i) |-> !$past(pix_valid_i && pix_ready_i))
    else $error("result raised directly after a pixel beat");

endmodule

bind rgb_box_average_downsampler_unit bxds_checker u_bxds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pix_valid_i  (pix_i.valid),
  .pix_ready_i  (pix_i.ready),
  .mean_valid_i (mean_o.valid),
  .mean_ready_i (mean_o.ready),
  .mean_red_i   (mean_o.mean_red),
  .mean_green_i (mean_o.mean_green),
  .mean_blue_i  (mean_o.mean_blue),
  .out_column_i (mean_o.out_column),
  .out_line_i   (mean_o.out_line),
  .pready_i     (pready)
);

`default_nettype wire
